>>> design/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared codes and types of the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam logic [1:0] FUNC_LOAD_A   = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B   = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE  = 2'd2;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  localparam logic [3:0] REG_A_ROWS = 4'd0;
  localparam logic [3:0] REG_A_COLS = 4'd1;
  localparam logic [3:0] REG_B_ROWS = 4'd2;
  localparam logic [3:0] REG_B_COLS = 4'd3;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;

  // control that travels along the chain with each a element
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } beat_ctrl_t;

endpackage

>>> design/mm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_cell
// One column cell: holds one column of B, multiplies the passing a element
// with its b entry, accumulates the dot product and saturates the result.
// ----------------------------------------------------------------------------
module mm_cell #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(MAX_DIM)-1:0] wr_addr,
  input  logic [31:0]                wr_data,
  input  mm_pkg::beat_ctrl_t         in_ctrl,
  input  logic [$clog2(MAX_DIM)-1:0] in_k,
  input  logic [31:0]                in_a,
  output mm_pkg::beat_ctrl_t         out_ctrl,
  output logic [$clog2(MAX_DIM)-1:0] out_k,
  output logic [31:0]                out_a,
  output logic [31:0]                res,
  output logic                       res_valid
);

  localparam int ACCW = 64 + $clog2(MAX_DIM);

  logic [31:0]            bank [MAX_DIM];
  logic signed [63:0]     prod;
  mm_pkg::beat_ctrl_t     p_ctrl;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] prod_ext;
  logic signed [ACCW-1:0] shifted;
  logic                   acc_done;
  logic                   fits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_addr] <= wr_data;
    end
  end

  // hand the a element on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl <= in_ctrl;
    end
    out_k <= in_k;
    out_a <= in_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctrl <= '0;
    end else begin
      p_ctrl <= in_ctrl;
    end
    prod <= $signed(in_a) * $signed(bank[in_k]);
  end

  assign prod_ext = {{(ACCW-64){prod[63]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else begin
      acc_done <= p_ctrl.valid && p_ctrl.last;
    end
    if (p_ctrl.valid) begin
      acc <= p_ctrl.first ? prod_ext : acc + prod_ext;
    end
  end

  assign shifted = acc >>> FRAC_BITS;
  assign fits    = (&shifted[ACCW-1:31]) || !(|shifted[ACCW-1:31]);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= acc_done;
    end
    if (acc_done) begin
      if (fits) begin
        res <= shifted[31:0];
      end else begin
        res <= shifted[ACCW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

endmodule

>>> design/matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply
// Fixed-point Q16.16 matrix product C = A * B over a chain of column cells.
// ----------------------------------------------------------------------------
// loads of A or B are taken one beat per cycle, but only while idle
// a compute runs, per row of C, a feed of a_cols beats
// through the A read port and the cell chain, then b_cols output beats
// a shape error beat goes from the error state into the output reg once that reg is free
// no new input beat is taken until all results are loaded into the output reg
// synchronous reset: control cleared, dimensions to 8, stores undefined
module matrix_multiply #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row, col, elem_value, zero pad
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // prod_value, out_row, out_col, zero pad
  output logic        m_tuser,   // shape_error
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FEED = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  function automatic logic [CW-1:0] clamp_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return CW'(1);
    end else if (32'(v) > MAX_DIM) begin
      return CW'(MAX_DIM);
    end else begin
      return CW'(v);
    end
  endfunction

  logic [2:0]  state;
  logic [3:0]  a_rows, a_cols, b_rows, b_cols;
  logic [CW-1:0] ar, ac, bc;
  logic [IW-1:0] r, k, c;

  logic [1:0]  in_func;
  logic [2:0]  in_row, in_col;
  logic [31:0] in_val;
  logic        in_fire, in_range;

  logic [31:0] a_mem [MAX_DIM*MAX_DIM];
  logic [31:0] a_rdata;
  logic [IW-1:0] f_k;
  mm_pkg::beat_ctrl_t f_ctrl;

  mm_pkg::beat_ctrl_t ch_ctrl [MAX_DIM+1];
  logic [IW-1:0] ch_k [MAX_DIM+1];
  logic [31:0]   ch_a [MAX_DIM+1];
  logic [31:0]   cell_res [MAX_DIM];
  logic          cell_done [MAX_DIM];

  logic        out_free;
  logic        out_load;
  logic [31:0] o_val;
  logic [2:0]  o_row, o_col;

  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[5:3];
  assign in_val   = s_tdata[37:6];
  assign in_func  = s_tuser;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state inside {ST_EMIT, ST_ERR});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= 4'd8;
      a_cols <= 4'd8;
      b_rows <= 4'd8;
      b_cols <= 4'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        mm_pkg::REG_A_ROWS: a_rows <= cfg_data;
        mm_pkg::REG_A_COLS: a_cols <= cfg_data;
        mm_pkg::REG_B_ROWS: b_rows <= cfg_data;
        mm_pkg::REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_func == mm_pkg::FUNC_LOAD_A && in_range) begin
      a_mem[AW'(32'(in_row) * MAX_DIM + 32'(in_col))] <= in_val;
    end
    a_rdata <= a_mem[AW'(32'(r) * MAX_DIM + 32'(k))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctrl <= '0;
    end else begin
      f_ctrl.valid <= (state == ST_FEED);
      f_ctrl.first <= (k == '0);
      f_ctrl.last  <= (CW'(k) == ac - CW'(1));
    end
    f_k <= k;
  end

  assign ch_ctrl[0] = f_ctrl;
  assign ch_k[0]    = f_k;
  assign ch_a[0]    = a_rdata;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    mm_cell #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (in_fire && in_func == mm_pkg::FUNC_LOAD_B && in_range &&
                  32'(in_col) == g),
      .wr_addr   (in_row[IW-1:0]),
      .wr_data   (in_val),
      .in_ctrl   (ch_ctrl[g]),
      .in_k      (ch_k[g]),
      .in_a      (ch_a[g]),
      .out_ctrl  (ch_ctrl[g+1]),
      .out_k     (ch_k[g+1]),
      .out_a     (ch_a[g+1]),
      .res       (cell_res[g]),
      .res_valid (cell_done[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      r <= '0;
      k <= '0;
      c <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && in_func == mm_pkg::FUNC_COMPUTE) begin
            ar <= clamp_dim(a_rows);
            ac <= clamp_dim(a_cols);
            bc <= clamp_dim(b_cols);
            r  <= '0;
            k  <= '0;
            c  <= '0;
            state <= (clamp_dim(a_cols) != clamp_dim(b_rows)) ? ST_ERR : ST_FEED;
          end
        end
        ST_FEED: begin
          if (CW'(k) == ac - CW'(1)) begin
            state <= ST_WAIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_WAIT: begin
          // last cell of the chain finishes last
          if (cell_done[MAX_DIM-1]) begin
            c     <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            o_val    <= cell_res[c];
            o_row    <= 3'(r);
            o_col    <= 3'(c);
            m_tuser  <= 1'b0;
            m_tlast  <= (CW'(c) == bc - CW'(1)) && (CW'(r) == ar - CW'(1));
            if (CW'(c) == bc - CW'(1)) begin
              if (CW'(r) == ar - CW'(1)) begin
                state <= ST_IDLE;
              end else begin
                r     <= r + 1'b1;
                k     <= '0;
                state <= ST_FEED;
              end
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            o_val    <= '0;
            o_row    <= '0;
            o_col    <= '0;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {2'b00, o_col, o_row, o_val};

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error beat without last");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cell_done[MAX_DIM-1] |-> state == ST_WAIT)
    else $error("chain result outside wait");

  a_no_feed_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> !f_ctrl.valid)
    else $error("feed active while emitting");

endmodule

>>> verif/mm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_checker
// Watches the load, result and register channels of the matrix multiplier,
// keeps its own copy of both stores and the dimensions, predicts every
// product beat and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module mm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        err;
    logic        last;
  } prod_beat_t;

  logic [31:0] a_mem [64];
  logic [31:0] b_mem [64];
  logic [3:0]  dims [4];
  prod_beat_t  product_q [$];

  function automatic int eff_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  // full-width sum, floor shift, saturate to 32 bits
  function automatic logic [31:0] dot_value(int r, int c, int n);
    logic signed [127:0] acc;
    logic signed [127:0] sh;
    acc = 0;
    for (int i = 0; i < n; i++)
      acc += 128'(signed'(a_mem[r*8+i])) * 128'(signed'(b_mem[i*8+c]));
    sh = acc >>> 16;
    if (sh > 128'sd2147483647) return 32'h7fffffff;
    if (sh < -128'sd2147483648) return 32'h80000000;
    return sh[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic predict_product();
    int ar, ac, br, bc;
    prod_beat_t e;
    ar = eff_dim(dims[0]); ac = eff_dim(dims[1]);
    br = eff_dim(dims[2]); bc = eff_dim(dims[3]);
    if (ac != br) begin
      e = '{value: 0, row: 0, col: 0, err: 1'b1, last: 1'b1};
      product_q.push_back(e);
      return;
    end
    for (int r = 0; r < ar; r++)
      for (int c = 0; c < bc; c++) begin
        e.value = dot_value(r, c, ac);
        e.row = r[2:0];
        e.col = c[2:0];
        e.err = 1'b0;
        e.last = (r == ar - 1) && (c == bc - 1);
        product_q.push_back(e);
      end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    prod_beat_t e;
    if (rst) begin
      dims[0] <= 8; dims[1] <= 8; dims[2] <= 8; dims[3] <= 8;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < 4) dims[cfg_index] <= cfg_data;
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          mm_pkg::FUNC_LOAD_A: a_mem[{s_tdata[2:0], s_tdata[5:3]}] = s_tdata[37:6];
          mm_pkg::FUNC_LOAD_B: b_mem[{s_tdata[2:0], s_tdata[5:3]}] = s_tdata[37:6];
          mm_pkg::FUNC_COMPUTE: predict_product();
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (product_q.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 0);
        end else begin
          e = product_q.pop_front();
          if (m_tdata[31:0] !== e.value) report_mismatch("prod_value", m_tdata[31:0], e.value);
          if (m_tdata[34:32] !== e.row) report_mismatch("out_row", m_tdata[34:32], e.row);
          if (m_tdata[37:35] !== e.col) report_mismatch("out_col", m_tdata[37:35], e.col);
          if (m_tuser !== e.err) report_mismatch("shape_error", m_tuser, e.err);
          if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
        end
      end
    end
    pending = product_q.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives loads, computes and dimension writes into the matrix multiplier,
// with random gaps and output stalls, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [3:0]  cfg_data;
  int          fail_count;
  int          pending;
  bit          calm;

  matrix_multiply DUT (.*);

  mm_checker u_checker (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // receiver stalls about 17 percent of the time except in calm stretches
  always @(posedge clk)
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);

  // valid stays up after the beat so back-to-back beats need no gap
  task automatic send_beat(logic [1:0] func, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    while (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, v, c, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_dim(logic [3:0] idx, logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // load every element so no compute reads an unwritten entry
  task automatic fill_all(bit extreme);
    logic [31:0] v;
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        for (int m = 0; m < 2; m++) begin
          v = extreme ? (($urandom_range(1)) ? 32'h7fffffff : 32'h80000000) : $urandom;
          send_beat(m ? mm_pkg::FUNC_LOAD_B : mm_pkg::FUNC_LOAD_A, r[2:0], c[2:0], v);
        end
  endtask

  task automatic set_dims(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
    drain();
    write_dim(mm_pkg::REG_A_ROWS, ar);
    write_dim(mm_pkg::REG_A_COLS, ac);
    write_dim(mm_pkg::REG_B_ROWS, br);
    write_dim(mm_pkg::REG_B_COLS, bc);
  endtask

  initial begin
    logic [3:0] k;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset dims, odd selector, shape error, clamped dims, bad reg index
    fill_all(1'b0);
    send_beat(mm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'd0);
    send_beat(mm_pkg::FUNC_RESERVED, 3'd7, 3'd7, 32'hffffffff);
    set_dims(4'd1, 4'd3, 4'd2, 4'd1);
    send_beat(mm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'd0);
    set_dims(4'd0, 4'd15, 4'd9, 4'd0);
    write_dim(4'd9, 4'd1);
    send_beat(mm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'd0);
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_beat(mm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'd0);

    // saturation at both ends: row 0 of A against column 0 of B
    for (int i = 0; i < 8; i++) begin
      send_beat(mm_pkg::FUNC_LOAD_A, 3'd0, i[2:0], 32'h80000000);
      send_beat(mm_pkg::FUNC_LOAD_B, i[2:0], 3'd0, 32'h80000000);
    end
    set_dims(4'd1, 4'd8, 4'd8, 4'd1);
    send_beat(mm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'd0);
    for (int i = 0; i < 8; i++)
      send_beat(mm_pkg::FUNC_LOAD_B, i[2:0], 3'd0, 32'h7fffffff);
    send_beat(mm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'd0);

    // random phases: mostly small shapes, random loads over all values
    for (int p = 0; p < 18; p++) begin
      calm = (p >= 6 && p < 13);
      k = 4'($urandom_range(8, 1));
      if (p % 10 == 9)
        set_dims(4'd8, 4'd8, 4'd8, 4'd8);
      else if (p % 7 == 3)
        set_dims(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
      else
        set_dims(4'($urandom_range(4, 1)), k, k, 4'($urandom_range(4, 1)));
      repeat (6) send_beat(2'($urandom_range(1)), 3'($urandom), 3'($urandom), $urandom);
      send_beat(mm_pkg::FUNC_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
      if ($urandom_range(3) == 0)
        send_beat(mm_pkg::FUNC_RESERVED, 3'($urandom), 3'($urandom), $urandom);
    end
    calm = 1'b0;
    drain();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
